@@ rtl/rid_pkg.sv @@
package rid_pkg;

   typedef logic [5:0] rid_mn_type;
   typedef rid_mn_type rid_row_type [8];

   // major opcode classes, instruction bits 6:2
   localparam logic [4:0] CLS_LOAD      = 5'd0;
   localparam logic [4:0] CLS_LOAD_FP   = 5'd1;
   localparam logic [4:0] CLS_MISC_MEM  = 5'd3;
   localparam logic [4:0] CLS_OP_IMM    = 5'd4;
   localparam logic [4:0] CLS_AUIPC     = 5'd5;
   localparam logic [4:0] CLS_OP_IMM_32 = 5'd6;
   localparam logic [4:0] CLS_STORE     = 5'd8;
   localparam logic [4:0] CLS_STORE_FP  = 5'd9;
   localparam logic [4:0] CLS_AMO       = 5'd11;
   localparam logic [4:0] CLS_OP        = 5'd12;
   localparam logic [4:0] CLS_LUI       = 5'd13;
   localparam logic [4:0] CLS_OP_32     = 5'd14;
   localparam logic [4:0] CLS_BRANCH    = 5'd24;
   localparam logic [4:0] CLS_JALR      = 5'd25;
   localparam logic [4:0] CLS_JAL       = 5'd27;
   localparam logic [4:0] CLS_SYSTEM    = 5'd28;

   localparam logic [1:0] OPC_LOW_32BIT = 2'b11;

   localparam logic [6:0] F7_ALT    = 7'h20;
   localparam logic [6:0] F7_MULDIV = 7'h01;
   localparam logic [6:0] F7_AMO_4  = 7'h04;
   localparam logic [6:0] F7_AMO_8  = 7'h08;
   localparam logic [6:0] F7_AMO_C  = 7'h0C;

   localparam logic [2:0] F3_SLL = 3'd1;
   localparam logic [2:0] F3_SRL = 3'd5;

   localparam rid_mn_type MN_NONE = 6'd0;
   localparam rid_mn_type MN_ADD  = 6'd13;
   localparam rid_mn_type MN_JALR = 6'd55;
   localparam rid_mn_type MN_JAL  = 6'd56;

   localparam logic [1:0] PK_NONE    = 2'd0;
   localparam logic [1:0] PK_JMP     = 2'd1;
   localparam logic [1:0] PK_MOV_IMM = 2'd2;
   localparam logic [1:0] PK_MOV_REG = 2'd3;

   // mnemonic rows, indexed by func3
   localparam rid_row_type ROW_LOAD     = '{6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd6, 6'd7, 6'd0};
   localparam rid_row_type ROW_LOAD_FP  = '{6'd0, 6'd0, 6'd8, 6'd9, 6'd0, 6'd0, 6'd0, 6'd0};
   localparam rid_row_type ROW_MISC_MEM = '{6'd10, 6'd11, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0};
   localparam rid_row_type ROW_ALU_ALT  = '{6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd12, 6'd0, 6'd0};
   localparam rid_row_type ROW_ALU      = '{6'd13, 6'd14, 6'd15, 6'd16,
                                            6'd17, 6'd18, 6'd19, 6'd20};
   localparam rid_row_type ROW_W_ALT    = '{6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd22, 6'd0, 6'd0};
   localparam rid_row_type ROW_W        = '{6'd23, 6'd24, 6'd0, 6'd0, 6'd0, 6'd25, 6'd0, 6'd0};
   localparam rid_row_type ROW_STORE    = '{6'd1, 6'd2, 6'd3, 6'd4, 6'd0, 6'd0, 6'd0, 6'd0};
   localparam rid_row_type ROW_AMO_4    = '{6'd0, 6'd0, 6'd26, 6'd27, 6'd0, 6'd0, 6'd0, 6'd0};
   localparam rid_row_type ROW_AMO_8    = '{6'd0, 6'd0, 6'd28, 6'd29, 6'd0, 6'd0, 6'd0, 6'd0};
   localparam rid_row_type ROW_AMO_C    = '{6'd0, 6'd0, 6'd30, 6'd31, 6'd0, 6'd0, 6'd0, 6'd0};
   localparam rid_row_type ROW_AMO      = '{6'd0, 6'd0, 6'd32, 6'd33, 6'd0, 6'd0, 6'd0, 6'd0};
   localparam rid_row_type ROW_MULDIV   = '{6'd34, 6'd35, 6'd36, 6'd37,
                                            6'd38, 6'd39, 6'd40, 6'd41};
   localparam rid_row_type ROW_OP_ALT   = '{6'd42, 6'd0, 6'd0, 6'd0, 6'd0, 6'd12, 6'd0, 6'd0};
   localparam rid_row_type ROW_MULDIV_W = '{6'd43, 6'd0, 6'd0, 6'd0, 6'd44, 6'd45, 6'd46, 6'd47};
   localparam rid_row_type ROW_OP_W_ALT = '{6'd48, 6'd0, 6'd0, 6'd0, 6'd0, 6'd22, 6'd0, 6'd0};
   localparam rid_row_type ROW_BRANCH   = '{6'd49, 6'd50, 6'd0, 6'd0, 6'd51, 6'd52, 6'd53, 6'd54};
   localparam rid_row_type ROW_SYSTEM   = '{6'd57, 6'd58, 6'd59, 6'd60, 6'd0, 6'd61, 6'd62, 6'd63};
   localparam rid_mn_type  MN_LUI       = 6'd21;

   typedef struct packed {
      logic              legal;
      rid_mn_type        mnemonic;
      logic [4:0]        major_class;
      logic [1:0]        pseudo_kind;
      logic [4:0]        dest_reg;
      logic [4:0]        src1_reg;
      logic [4:0]        src2_reg;
      logic [4:0]        src3_reg;
      logic [6:0]        funct7_field;
      logic signed [31:0] immediate;
      logic [63:0]       branch_target;
   } rid_result_type;

endpackage

@@ rtl/riscv_instruction_decoder.sv @@
// Throughput: one instruction per cycle while rsp_ready is high; the input
// register and the result register form a two-stage pipeline with one decode
// pass between them, and a result shows on rsp_valid from the result register.
// Reset: synchronous, active high; clears both stage valid flags, so no result
// is pending and req_ready is high in the first cycle after reset.
module riscv_instruction_decoder
   import rid_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [31:0]        req_instr_word,
   input  logic [63:0]        req_pc,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_legal,
   output logic [5:0]         rsp_mnemonic,
   output logic [4:0]         rsp_major_class,
   output logic [1:0]         rsp_pseudo_kind,
   output logic [4:0]         rsp_dest_reg,
   output logic [4:0]         rsp_src1_reg,
   output logic [4:0]         rsp_src2_reg,
   output logic [4:0]         rsp_src3_reg,
   output logic [6:0]         rsp_funct7_field,
   output logic signed [31:0] rsp_immediate,
   output logic [63:0]        rsp_branch_target
);

   logic           in_valid_ff, in_valid_in;
   logic [31:0]    in_word_ff;
   logic [63:0]    in_pc_ff;
   logic           out_valid_ff, out_valid_in;
   rid_result_type out_ff;
   rid_result_type dec_result;
   logic           out_free;
   logic           in_move;
   logic           req_xfer;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign in_move   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;
   assign req_xfer  = req_valid && req_ready;

   always_comb begin
      if (req_xfer) in_valid_in = 1'b1;
      else if (in_move) in_valid_in = 1'b0;
      else in_valid_in = in_valid_ff;
      out_valid_in = out_free ? in_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_word_ff <= req_instr_word;
         in_pc_ff   <= req_pc;
      end
      if (in_move) out_ff <= dec_result;
   end

   rid_decode u_decode (
      .instr_word (in_word_ff),
      .pc         (in_pc_ff),
      .result     (dec_result)
   );

   assign rsp_valid         = out_valid_ff;
   assign rsp_legal         = out_ff.legal;
   assign rsp_mnemonic      = out_ff.mnemonic;
   assign rsp_major_class   = out_ff.major_class;
   assign rsp_pseudo_kind   = out_ff.pseudo_kind;
   assign rsp_dest_reg      = out_ff.dest_reg;
   assign rsp_src1_reg      = out_ff.src1_reg;
   assign rsp_src2_reg      = out_ff.src2_reg;
   assign rsp_src3_reg      = out_ff.src3_reg;
   assign rsp_funct7_field  = out_ff.funct7_field;
   assign rsp_immediate     = out_ff.immediate;
   assign rsp_branch_target = out_ff.branch_target;

endmodule

@@ rtl/rid_decode.sv @@
module rid_decode
   import rid_pkg::*;
(
   input  logic [31:0]    instr_word,
   input  logic [63:0]    pc,
   output rid_result_type result
);

   function automatic rid_mn_type mn_lookup(input logic [4:0] major,
                                            input logic [6:0] f7,
                                            input logic [2:0] f3);
      rid_mn_type mn;
      mn = MN_NONE;
      case (major)
         CLS_LOAD:     mn = ROW_LOAD[f3];
         CLS_LOAD_FP:  mn = ROW_LOAD_FP[f3];
         CLS_MISC_MEM: mn = ROW_MISC_MEM[f3];
         CLS_OP_IMM: begin
            if (f7 == F7_ALT && ROW_ALU_ALT[f3] != MN_NONE) mn = ROW_ALU_ALT[f3];
            else mn = ROW_ALU[f3];
         end
         CLS_AUIPC:    mn = MN_LUI;
         CLS_OP_IMM_32: begin
            if (f7 == F7_ALT && ROW_W_ALT[f3] != MN_NONE) mn = ROW_W_ALT[f3];
            else mn = ROW_W[f3];
         end
         CLS_STORE:    mn = ROW_STORE[f3];
         CLS_STORE_FP: mn = ROW_LOAD_FP[f3];
         CLS_AMO: begin
            if (f7 == F7_AMO_4 && ROW_AMO_4[f3] != MN_NONE) mn = ROW_AMO_4[f3];
            else if (f7 == F7_AMO_8 && ROW_AMO_8[f3] != MN_NONE) mn = ROW_AMO_8[f3];
            else if (f7 == F7_AMO_C && ROW_AMO_C[f3] != MN_NONE) mn = ROW_AMO_C[f3];
            else mn = ROW_AMO[f3];
         end
         CLS_OP: begin
            if (f7 == F7_MULDIV) mn = ROW_MULDIV[f3];
            else if (f7 == F7_ALT && ROW_OP_ALT[f3] != MN_NONE) mn = ROW_OP_ALT[f3];
            else mn = ROW_ALU[f3];
         end
         CLS_LUI:      mn = MN_LUI;
         CLS_OP_32: begin
            if (f7 == F7_MULDIV && ROW_MULDIV_W[f3] != MN_NONE) mn = ROW_MULDIV_W[f3];
            else if (f7 == F7_ALT && ROW_OP_W_ALT[f3] != MN_NONE) mn = ROW_OP_W_ALT[f3];
            else mn = ROW_W[f3];
         end
         CLS_BRANCH:   mn = ROW_BRANCH[f3];
         CLS_JALR:     mn = MN_JALR;
         CLS_JAL:      mn = MN_JAL;
         CLS_SYSTEM:   mn = ROW_SYSTEM[f3];
         default:      mn = MN_NONE;
      endcase
      return mn;
   endfunction

   logic [4:0]         major;
   logic [2:0]         f3;
   logic [31:0]        imm;
   rid_mn_type         mn;
   logic [1:0]         pk;

   assign major = instr_word[6:2];
   assign f3    = instr_word[14:12];

   always_comb begin
      case (major)
         CLS_STORE, CLS_STORE_FP:
            imm = {{20{instr_word[31]}}, instr_word[31:25], instr_word[11:7]};
         CLS_BRANCH:
            imm = {{19{instr_word[31]}}, instr_word[31], instr_word[7],
                   instr_word[30:25], instr_word[11:8], 1'b0};
         CLS_OP_IMM, CLS_OP_IMM_32: begin
            // shift forms carry a plain shift amount
            if (f3 == F3_SLL || f3 == F3_SRL) imm = {27'd0, instr_word[24:20]};
            else imm = {{20{instr_word[31]}}, instr_word[31:20]};
         end
         CLS_LOAD, CLS_LOAD_FP, CLS_MISC_MEM, CLS_JALR, CLS_SYSTEM:
            imm = {{20{instr_word[31]}}, instr_word[31:20]};
         CLS_AUIPC, CLS_LUI:
            imm = {instr_word[31:12], 12'd0};
         CLS_JAL:
            imm = {{11{instr_word[31]}}, instr_word[31], instr_word[19:12],
                   instr_word[20], instr_word[30:21], 1'b0};
         default:
            imm = 32'd0;
      endcase
   end

   always_comb begin
      if (instr_word[1:0] == OPC_LOW_32BIT) mn = mn_lookup(major, instr_word[31:25], f3);
      else mn = MN_NONE;
   end

   always_comb begin
      pk = PK_NONE;
      if (mn == MN_JAL || mn == MN_JALR) begin
         if (instr_word[11:7] == 5'd0) pk = PK_JMP;
      end else if (mn == MN_ADD && major == CLS_OP_IMM) begin
         if (instr_word[19:15] == 5'd0) pk = PK_MOV_IMM;
         else if (imm == 32'd0) pk = PK_MOV_REG;
      end
   end

   always_comb begin
      result.legal         = (mn != MN_NONE);
      result.mnemonic      = mn;
      result.major_class   = major;
      result.pseudo_kind   = pk;
      result.dest_reg      = instr_word[11:7];
      result.src1_reg      = instr_word[19:15];
      result.src2_reg      = instr_word[24:20];
      result.src3_reg      = instr_word[31:27];
      result.funct7_field  = instr_word[31:25];
      result.immediate     = imm;
      result.branch_target = pc + {{32{imm[31]}}, imm};
   end

endmodule

@@ rtl/rid_checker.sv @@
module rid_checker
   import rid_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_legal,
   input logic [5:0]         rsp_mnemonic,
   input logic [1:0]         rsp_pseudo_kind,
   input logic [4:0]         rsp_dest_reg,
   input logic [4:0]         rsp_src1_reg,
   input logic signed [31:0] rsp_immediate,
   input logic [63:0]        rsp_branch_target
);

   // a stalled result holds until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mnemonic)
         && $stable(rsp_branch_target) && $stable(rsp_immediate))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

   a_legal_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_legal == (rsp_mnemonic != MN_NONE))
         && (rsp_legal || rsp_pseudo_kind == PK_NONE))
      else $error("legal flag disagrees with mnemonic");

   a_jmp_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pseudo_kind == PK_JMP |->
         (rsp_mnemonic == MN_JAL || rsp_mnemonic == MN_JALR) && rsp_dest_reg == 5'd0)
      else $error("jump pseudo form on wrong instruction");

   a_mov_reg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pseudo_kind == PK_MOV_REG |->
         rsp_immediate == 32'sd0 && rsp_src1_reg != 5'd0 && rsp_mnemonic == MN_ADD)
      else $error("register move pseudo form on wrong instruction");

endmodule

bind riscv_instruction_decoder rid_checker u_rid_checker (.*);
